[src/tksa_pkg.sv]
// Package for the three-key setpoint adjuster: constants, register indexes, helpers.
package tksa_pkg;

  // Key order is fixed: down, up, fine
  localparam int KEY_COUNT = 3;
  localparam int KEY_DOWN  = 0;
  localparam int KEY_UP    = 1;
  localparam int KEY_FINE  = 2;

  localparam int TIME_W  = 32;
  localparam int SP_W    = 16;
  localparam int SAVE_W  = 17;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Stream payload widths, padded to whole bytes
  localparam int IN_FIELDS_W  = TIME_W + 4;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SP_W + 1 + 1 + SAVE_W + 1 + 1 + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_MS         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COARSE_STEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINE_STEP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_MAX     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_INITIAL = 3'd5;

  // Register reset values
  localparam logic [CFG_W-1:0] GUARD_MS_RST         = 16'd100;
  localparam logic [CFG_W-1:0] LONG_PRESS_MS_RST    = 16'd2000;
  localparam logic [CFG_W-1:0] COARSE_STEP_RST      = 16'd100;
  localparam logic [CFG_W-1:0] FINE_STEP_RST        = 16'd10;
  localparam logic [CFG_W-1:0] SETPOINT_MAX_RST     = 16'd5000;
  localparam logic [CFG_W-1:0] SETPOINT_INITIAL_RST = 16'd0;

  typedef struct packed {
    logic              sleep_request;
    logic              fine_key_level;
    logic              up_key_level;
    logic              down_key_level;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic              asleep;
    logic              activity_pulse;
    logic              redraw_pulse;
    logic [SAVE_W-1:0] saved_setpoint;
    logic              save_pulse;
    logic              setpoint_changed;
    logic [SP_W-1:0]   setpoint;
  } out_item_t;

  // Saturating increment; never lowers a setpoint already at or over the ceiling
  function automatic logic [SP_W-1:0] raise_setpoint(input logic [SP_W-1:0] sp,
                                                     input logic [SP_W-1:0] step,
                                                     input logic [SP_W-1:0] ceil);
    logic [SP_W:0] sum;
    sum = {1'b0, sp} + {1'b0, step};
    if (sp >= ceil) begin
      raise_setpoint = sp;
    end else if (sum > {1'b0, ceil}) begin
      raise_setpoint = ceil;
    end else begin
      raise_setpoint = sum[SP_W-1:0];
    end
  endfunction

  // Setpoint * 1.25, truncated
  function automatic logic [SAVE_W-1:0] scale_save(input logic [SP_W-1:0] sp);
    logic [SP_W+2:0] prod;
    prod = {3'b000, sp} + {1'b0, sp, 2'b00};
    scale_save = prod[SP_W+2:2];
  endfunction

endpackage

[src/three_key_setpoint_adjuster.sv]
// Three-key setpoint adjuster: short/long press detection and setpoint stepping.
//
//  channel      | direction | payload
//  -------------+-----------+-----------------------------------------------
//  s_axis       | in        | one key sample per request (time, 3 keys, sleep)
//  m_axis       | out       | one result per sample (setpoint and pulses)
//  cfg          | in        | register write, index 0..5, 16-bit data
//
// A sample lands in the input register, then combinational logic updates the
// key latches, setpoint and sleep flag and loads the result register.
// Throughput is one sample per cycle unless the output stalls.
// rst is synchronous: latches, edge times and sleep clear, the setpoint takes
// the initial value, registers return to their defaults.
// A stalled output holds its result; the input register takes one more sample,
// then the input stalls until the result is taken.
module three_key_setpoint_adjuster (
  input  logic                              clk,
  input  logic                              rst,
  // tdata: now_ms[31:0], down_key_level, up_key_level, fine_key_level,
  //        sleep_request, zero pad
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tksa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tdata: setpoint[15:0], setpoint_changed, save_pulse, saved_setpoint[16:0],
  //        redraw_pulse, activity_pulse, asleep, zero pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tksa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_wr_en,
  input  logic [tksa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tksa_pkg::CFG_W-1:0]        cfg_wdata
);
  import tksa_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0] guard_ms;
  logic [CFG_W-1:0] long_press_ms;
  logic [CFG_W-1:0] coarse_step;
  logic [CFG_W-1:0] fine_step;
  logic [CFG_W-1:0] setpoint_max;
  logic [CFG_W-1:0] setpoint_initial;

  // Input register
  logic     in_vld;
  in_item_t in_item;

  // Key and setpoint state
  logic [KEY_COUNT-1:0] press_latch, press_latch_next;
  logic [KEY_COUNT-1:0] long_latch, long_latch_next;
  logic [TIME_W-1:0]    edge_time [KEY_COUNT];
  logic [TIME_W-1:0]    edge_time_next [KEY_COUNT];
  logic [SP_W-1:0]      setpoint_reg, setpoint_next;
  logic                 sleep_flag, sleep_next;

  // Result register
  logic      out_vld;
  out_item_t out_item, out_next;

  logic advance;

  assign advance       = in_vld && (!out_vld || m_axis_tready);
  assign s_axis_tready = !in_vld || advance;

  // Register writes; setpoint_initial takes effect at the next reset
  always_ff @(posedge clk) begin
    if (rst) begin
      guard_ms         <= GUARD_MS_RST;
      long_press_ms    <= LONG_PRESS_MS_RST;
      coarse_step      <= COARSE_STEP_RST;
      fine_step        <= FINE_STEP_RST;
      setpoint_max     <= SETPOINT_MAX_RST;
      setpoint_initial <= SETPOINT_INITIAL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GUARD_MS:         guard_ms         <= cfg_wdata;
        REG_LONG_PRESS_MS:    long_press_ms    <= cfg_wdata;
        REG_COARSE_STEP:      coarse_step      <= cfg_wdata;
        REG_FINE_STEP:        fine_step        <= cfg_wdata;
        REG_SETPOINT_MAX:     setpoint_max     <= cfg_wdata;
        REG_SETPOINT_INITIAL: setpoint_initial <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= s_axis_tdata[IN_FIELDS_W-1:0];
    end
  end

  // Per-key evaluation, keys in order down, up, fine on a running setpoint
  always_comb begin
    logic [TIME_W-1:0] elapsed;
    logic              held;
    logic              past_guard;
    logic              past_long;
    logic [SP_W-1:0]   sp;
    logic [SP_W-1:0]   sp_new;
    logic              slp;
    sp               = setpoint_reg;
    slp              = sleep_flag || in_item.sleep_request;
    press_latch_next = press_latch;
    long_latch_next  = long_latch;
    out_next         = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      edge_time_next[k] = edge_time[k];
    end
    for (int k = 0; k < KEY_COUNT; k++) begin
      case (k)
        KEY_DOWN: held = !in_item.down_key_level;
        KEY_UP:   held = !in_item.up_key_level;
        default:  held = !in_item.fine_key_level;
      endcase
      elapsed    = in_item.now_ms - edge_time[k];
      past_guard = elapsed > {{(TIME_W-CFG_W){1'b0}}, guard_ms};
      past_long  = elapsed > {{(TIME_W-CFG_W){1'b0}}, long_press_ms};
      sp_new     = sp;
      if (held && !press_latch[k] && past_guard) begin
        // press edge
        press_latch_next[k] = 1'b1;
        long_latch_next[k]  = 1'b0;
        edge_time_next[k]   = in_item.now_ms;
      end else if (held && !long_latch[k] && past_long) begin
        // long press
        long_latch_next[k] = 1'b1;
        if (k == KEY_UP) begin
          out_next.redraw_pulse   = 1'b1;
          out_next.activity_pulse = 1'b1;
          slp                     = 1'b0;
        end else if (k == KEY_FINE) begin
          out_next.save_pulse     = 1'b1;
          out_next.saved_setpoint = scale_save(sp);
          out_next.redraw_pulse   = 1'b1;
          out_next.activity_pulse = 1'b1;
        end
      end else if (!held && press_latch[k] && past_guard) begin
        // release edge, short action unless it was a long press
        press_latch_next[k] = 1'b0;
        edge_time_next[k]   = in_item.now_ms;
        if (!long_latch[k]) begin
          if (!slp) begin
            if (k == KEY_DOWN) begin
              if (sp >= coarse_step) begin
                sp_new = sp - coarse_step;
              end
            end else if (k == KEY_UP) begin
              sp_new = raise_setpoint(sp, coarse_step, setpoint_max);
            end else begin
              sp_new = raise_setpoint(sp, fine_step, setpoint_max);
            end
          end
          if (sp_new != sp) begin
            out_next.setpoint_changed = 1'b1;
          end
          out_next.activity_pulse = 1'b1;
        end
      end
      sp = sp_new;
    end
    setpoint_next     = sp;
    sleep_next        = slp;
    out_next.setpoint = sp;
    out_next.asleep   = slp;
  end

  // State update, one sample per advance
  always_ff @(posedge clk) begin
    if (rst) begin
      press_latch  <= '0;
      long_latch   <= '0;
      setpoint_reg <= setpoint_initial;
      sleep_flag   <= 1'b0;
      for (int k = 0; k < KEY_COUNT; k++) begin
        edge_time[k] <= '0;
      end
    end else if (advance) begin
      press_latch  <= press_latch_next;
      long_latch   <= long_latch_next;
      setpoint_reg <= setpoint_next;
      sleep_flag   <= sleep_next;
      for (int k = 0; k < KEY_COUNT; k++) begin
        edge_time[k] <= edge_time_next[k];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= out_next;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, out_item};

`ifndef SYNTHESIS
  // Input side only stalls when a result is waiting on a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // A save value only appears with its pulse
  a_save_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !out_item.save_pulse) |-> (out_item.saved_setpoint == '0))
    else $error("saved_setpoint set without save_pulse");

  // Redraw comes only from long actions, which also restart the idle timer
  a_redraw_activity: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_item.redraw_pulse) |-> out_item.activity_pulse)
    else $error("redraw without activity");

  // Setpoint state only moves on an advancing sample
  a_sp_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(setpoint_reg))
    else $error("setpoint changed without a sample");
`endif

endmodule

[sim/setpoint_checker.sv]
// Checker for the setpoint adjuster: watches both streams and the register port, predicts, compares.
module setpoint_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // tdata: now_ms[31:0], down_key_level, up_key_level, fine_key_level,
  //        sleep_request, zero pad
  input  logic [tksa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: setpoint[15:0], setpoint_changed, save_pulse, saved_setpoint[16:0],
  //        redraw_pulse, activity_pulse, asleep, zero pad
  input  logic [tksa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_wr_en,
  input  logic [tksa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tksa_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            end_check,
  output int                              outstanding,
  output int                              errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import tksa_pkg::*;

  // Register copies
  logic [CFG_W-1:0] guard_ms_q;
  logic [CFG_W-1:0] long_press_q;
  logic [CFG_W-1:0] coarse_q;
  logic [CFG_W-1:0] fine_q;
  logic [CFG_W-1:0] sp_ceiling;
  logic [CFG_W-1:0] sp_initial_q;

  // Key and setpoint state
  logic [KEY_COUNT-1:0] pressed;
  logic [KEY_COUNT-1:0] held_long;
  logic [TIME_W-1:0]    edge_stamp [KEY_COUNT];
  logic [SP_W-1:0]      level;
  logic                 dozing;

  // One predicted result per accepted request, oldest first
  out_item_t tick_results_q [$];
  int        results_seen = 0;
  int        err_count = 0;
  int        pending = 0;
  bit        closed = 1'b0;

  assign errors      = err_count;
  assign outstanding = pending;

  // One line per mismatch, and count it
  task automatic flag_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  task automatic cmp_field(input string field, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                              results_seen, field, got, want));
  endtask

  task automatic reset_model();
    guard_ms_q   = GUARD_MS_RST;
    long_press_q = LONG_PRESS_MS_RST;
    coarse_q     = COARSE_STEP_RST;
    fine_q       = FINE_STEP_RST;
    sp_ceiling   = SETPOINT_MAX_RST;
    sp_initial_q = SETPOINT_INITIAL_RST;
    pressed      = '0;
    held_long    = '0;
    for (int k = 0; k < KEY_COUNT; k++) edge_stamp[k] = '0;
    level        = sp_initial_q;
    dozing       = 1'b0;
  endtask

  // Increment that saturates at the ceiling and never pulls a high setpoint down
  function automatic logic [SP_W-1:0] capped_add(input logic [SP_W-1:0] base,
                                                 input logic [SP_W-1:0] inc);
    logic [SP_W:0] total;
    total = {1'b0, base} + {1'b0, inc};
    if (base >= sp_ceiling) return base;
    if (total > {1'b0, sp_ceiling}) return sp_ceiling;
    return total[SP_W-1:0];
  endfunction

  // One tick: sleep request first, then keys down, up, fine on the running state
  task automatic advance_keys(input in_item_t smp, output out_item_t res);
    logic [KEY_COUNT-1:0] held;
    logic [TIME_W-1:0]    span;
    logic [SP_W-1:0]      next_sp;
    logic [SP_W+2:0]      prod;
    res  = '0;
    held = ~{smp.fine_key_level, smp.up_key_level, smp.down_key_level};
    if (smp.sleep_request) dozing = 1'b1;
    for (int k = 0; k < KEY_COUNT; k++) begin
      span = smp.now_ms - edge_stamp[k];
      if (held[k] && !pressed[k] && span > guard_ms_q) begin
        pressed[k]    = 1'b1;
        held_long[k]  = 1'b0;
        edge_stamp[k] = smp.now_ms;
      end else if (held[k] && !held_long[k] && span > long_press_q) begin
        held_long[k] = 1'b1;
        if (k == KEY_UP) begin
          res.redraw_pulse   = 1'b1;
          res.activity_pulse = 1'b1;
          dozing             = 1'b0;
        end else if (k == KEY_FINE) begin
          prod               = level * 19'd5;
          res.save_pulse     = 1'b1;
          res.saved_setpoint = prod[SP_W+2:2];
          res.redraw_pulse   = 1'b1;
          res.activity_pulse = 1'b1;
        end
      end else if (!held[k] && pressed[k] && span > guard_ms_q) begin
        pressed[k]    = 1'b0;
        edge_stamp[k] = smp.now_ms;
        if (!held_long[k]) begin
          next_sp = level;
          if (!dozing) begin
            if (k == KEY_DOWN) begin
              if (level >= coarse_q) next_sp = level - coarse_q;
            end else if (k == KEY_UP) begin
              next_sp = capped_add(level, coarse_q);
            end else begin
              next_sp = capped_add(level, fine_q);
            end
          end
          if (next_sp != level) res.setpoint_changed = 1'b1;
          level              = next_sp;
          res.activity_pulse = 1'b1;
        end
      end
    end
    res.setpoint = level;
    res.asleep   = dozing;
  endtask

  always @(posedge clk) begin : watch
    in_item_t  smp;
    out_item_t got;
    out_item_t want;
    if (rst) begin
      reset_model();
      tick_results_q.delete();
    end else begin
      // Register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_GUARD_MS:         guard_ms_q   = cfg_wdata;
          REG_LONG_PRESS_MS:    long_press_q = cfg_wdata;
          REG_COARSE_STEP:      coarse_q     = cfg_wdata;
          REG_FINE_STEP:        fine_q       = cfg_wdata;
          REG_SETPOINT_MAX:     sp_ceiling   = cfg_wdata;
          REG_SETPOINT_INITIAL: sp_initial_q = cfg_wdata;
          default: ;
        endcase
      end
      // Result side: compare against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = out_item_t'(m_axis_tdata[OUT_FIELDS_W-1:0]);
        if (tick_results_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with no request pending", results_seen));
        end else begin
          want = tick_results_q.pop_front();
          cmp_field("setpoint", got.setpoint, want.setpoint);
          cmp_field("setpoint_changed", got.setpoint_changed, want.setpoint_changed);
          cmp_field("save_pulse", got.save_pulse, want.save_pulse);
          cmp_field("saved_setpoint", got.saved_setpoint, want.saved_setpoint);
          cmp_field("redraw_pulse", got.redraw_pulse, want.redraw_pulse);
          cmp_field("activity_pulse", got.activity_pulse, want.activity_pulse);
          cmp_field("asleep", got.asleep, want.asleep);
          cmp_field("pad", m_axis_tdata[OUT_DATA_W-1:OUT_FIELDS_W], '0);
        end
        results_seen++;
      end
      // Request side: predict
      if (s_axis_tvalid && s_axis_tready) begin
        smp = in_item_t'(s_axis_tdata[IN_FIELDS_W-1:0]);
        advance_keys(smp, want);
        tick_results_q.push_back(want);
      end
      // Final sweep for predictions that never got a result
      if (end_check && !closed) begin
        closed = 1'b1;
        if (tick_results_q.size() != 0)
          flag_mismatch($sformatf("%0d predicted results never arrived", tick_results_q.size()));
      end
    end
    pending = tick_results_q.size();
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the setpoint adjuster: clock, reset, stimulus, register phases and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tksa_pkg::*;

  // Indexes past the last register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int PHASE_COUNT   = 7;
  localparam int PHASE_ITEMS   = 270;
  localparam int CALM_PHASE    = 3;
  localparam int SETTLE_CYCLES = 6;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  end_check = 1'b0;
  int                    outstanding;
  int                    errors;

  // No gaps or stalls while calm is set
  logic                  calm = 1'b0;
  // Virtual millisecond clock and which keys the stimulus holds down
  logic [TIME_W-1:0]     ms_clock = '0;
  logic [KEY_COUNT-1:0]  keys_held = '0;
  logic [CFG_W-1:0]      guard_now = GUARD_MS_RST;
  logic [CFG_W-1:0]      long_now = LONG_PRESS_MS_RST;

  three_key_setpoint_adjuster u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  setpoint_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .end_check     (end_check),
    .outstanding   (outstanding),
    .errors        (errors)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side is stalled at random about a fifth of the time, unless calm is set
  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Pressed flags in, active-low levels out
  function automatic in_item_t key_sample(input logic [TIME_W-1:0] t, input logic dn,
                                          input logic up, input logic fn, input logic slp);
    in_item_t smp;
    smp.now_ms         = t;
    smp.down_key_level = ~dn;
    smp.up_key_level   = ~up;
    smp.fine_key_level = ~fn;
    smp.sleep_request  = slp;
    return smp;
  endfunction

  // Offer one request after a random gap and hold it until taken
  task automatic send_sample(input in_item_t smp);
    while (!calm && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, smp};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result is out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_setting(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] l,
                              input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] f,
                              input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] init);
    put_reg(REG_GUARD_MS, g);
    put_reg(REG_LONG_PRESS_MS, l);
    put_reg(REG_COARSE_STEP, c);
    put_reg(REG_FINE_STEP, f);
    put_reg(REG_SETPOINT_MAX, m);
    put_reg(REG_SETPOINT_INITIAL, init);
    put_reg(REG_SPARE_A, 16'($urandom()));
    put_reg(REG_SPARE_B, 16'($urandom()));
    cfg_wr_en <= 1'b0;
    guard_now = g;
    long_now  = l;
  endtask

  // Mostly press/hold/release traffic with gaps around the guard and long times, some noise
  task automatic run_phase(input int n);
    in_item_t          smp;
    logic [TIME_W-1:0] gap;
    int                k;
    repeat (n) begin
      if ($urandom_range(0, 99) < 5) begin
        smp = {4'($urandom_range(0, 15)), $urandom()};
      end else begin
        case ($urandom_range(0, 7))
          0:       gap = $urandom_range(0, guard_now);
          1:       gap = 32'(guard_now);
          2:       gap = 32'(guard_now) + 32'd1;
          3:       gap = 32'(long_now);
          4:       gap = 32'(long_now) + 32'd1;
          5:       gap = $urandom_range(0, long_now + guard_now + 2);
          6:       gap = $urandom_range(0, 200000);
          default: gap = $urandom_range(0, 3);
        endcase
        ms_clock = ms_clock + gap;
        for (k = 0; k < KEY_COUNT; k++) begin
          if ($urandom_range(0, 99) < 30) keys_held[k] = ~keys_held[k];
        end
        smp = key_sample(ms_clock, keys_held[KEY_DOWN], keys_held[KEY_UP],
                         keys_held[KEY_FINE], $urandom_range(0, 99) < 4);
      end
      send_sample(smp);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: sleep, wake by long up, bounce inside guard, each short step,
    // down below its step, all keys in one tick, save while asleep,
    // short press while asleep, long down, press and release across the wrap
    send_sample(key_sample(32'd0,    1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'd50,   1'b0, 1'b0, 1'b0, 1'b1));
    send_sample(key_sample(32'd200,  1'b0, 1'b1, 1'b0, 1'b0));
    send_sample(key_sample(32'd2300, 1'b0, 1'b1, 1'b0, 1'b0));
    send_sample(key_sample(32'd2400, 1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'd2600, 1'b0, 1'b1, 1'b0, 1'b0));
    send_sample(key_sample(32'd2650, 1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'd2701, 1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'd2900, 1'b1, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'd3001, 1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'd3200, 1'b1, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'd3400, 1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'd3600, 1'b0, 1'b0, 1'b1, 1'b0));
    send_sample(key_sample(32'd3800, 1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'd4000, 1'b1, 1'b1, 1'b1, 1'b0));
    send_sample(key_sample(32'd4200, 1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'd4400, 1'b0, 1'b0, 1'b1, 1'b1));
    send_sample(key_sample(32'd6500, 1'b0, 1'b0, 1'b1, 1'b0));
    send_sample(key_sample(32'd6600, 1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'd6700, 1'b0, 1'b1, 1'b0, 1'b0));
    send_sample(key_sample(32'd6900, 1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'd7000, 1'b1, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'd9100, 1'b1, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'd9200, 1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0));
    send_sample(key_sample(32'h0000_0100, 1'b0, 1'b0, 1'b0, 1'b0));

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      case (p)
        0: load_setting(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        1: load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: load_setting(GUARD_MS_RST, LONG_PRESS_MS_RST, COARSE_STEP_RST, FINE_STEP_RST,
                        SETPOINT_MAX_RST, 16'd1234);
        3: load_setting(16'd3, 16'd20, 16'd7, 16'd1, 16'd60, 16'd42);
        6: load_setting(16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFE, 16'd0);
        default: load_setting(16'($urandom_range(1, 500)), 16'($urandom_range(1, 4000)),
                              16'($urandom_range(0, 2000)), 16'($urandom_range(0, 300)),
                              16'($urandom()), 16'($urandom()));
      endcase
      ms_clock = $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 300000);
      calm <= (p == CALM_PHASE);
      run_phase(PHASE_ITEMS);
    end

    wait_idle();
    end_check <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
